/* rtl/mfd_pkg.sv */
package mfd_pkg;

  // fixed-point format of angles, speed and current
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int ENC_W   = 13;
  localparam int APC_W   = 24;
  localparam int R2D_W   = 24;
  localparam int ALPHA_W = 17;
  localparam int RPM_W   = 16;
  localparam int CUR_W   = 16;
  localparam int TEMP_W  = 8;
  localparam int ANG_W   = 25;
  localparam int TURN_W  = 32;
  localparam int TOT_W   = 48;
  localparam int SPD_W   = 41;
  localparam int CURF_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // shared multiplier
  localparam int MUL_XW = 26;
  localparam int MUL_YW = 18;
  localparam int MUL_PW = MUL_XW + MUL_YW;
  localparam int LO_W   = 24;  // low slice of a filter difference

  // derived formats
  localparam int ANG_SH = APC_W - FRAC_BITS;
  localparam int SHL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SPW    = SPD_W + 1 + SHL;
  localparam int CWW    = (CUR_W + FRAC_BITS > CURF_W + 1) ? CUR_W + FRAC_BITS : CURF_W + 1;
  localparam int SDF_W  = SPD_W + 1;
  localparam int CDF_W  = CURF_W + 1;
  localparam int M_W    = TURN_W + 9;
  localparam int M_KEEP = TOT_W - FRAC_BITS;
  localparam int TSW    = TOT_W + 1;

  localparam logic [ENC_W-1:0]   ENC_WRAP  = 13'd8191;
  localparam logic [ENC_W:0]     HALF_TURN = 14'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENC_OFFSET      = 3'd0,
    REG_ANGLE_PER_COUNT = 3'd1,
    REG_RPM_TO_DPS      = 3'd2,
    REG_SPEED_ALPHA     = 3'd3,
    REG_CURRENT_ALPHA   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MOP_ANG,
    MOP_RPM,
    MOP_SLO,
    MOP_SHI,
    MOP_CLO,
    MOP_CHI
  } mop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_ANG,
    ST_RPM,
    ST_DIFF,
    ST_SLO,
    ST_SHI,
    ST_CLO,
    ST_CHI,
    ST_CACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    mop_t mop;
    logic ld_in;
    logic ld_enc;
    logic ld_ang;
    logic ld_turn;
    logic ld_diff;
    logic ld_plo;
    logic upd_spd;
    logic upd_cur;
    logic ld_out;
  } ctl_t;

endpackage

/* rtl/motor_feedback_decoder.sv */
// Motor feedback decoder: one feedback frame in, one decoded word out.
// Input channel: in_valid / in_stall with enc_raw, speed_rpm, current_raw,
// temp_raw. Output channel: out_valid / out_stall with the zeroed count,
// single-turn angle, turn count, total angle, filtered speed and current,
// and the temperature byte.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// the register, cfg_data carries the value; unknown indexes are dropped.
// Write config only while no frame is in flight.
// From acceptance to the output register a frame is stepped by the sequencer: one
// 26x18 multiplier is reused six times by the sequencer (angle scaling,
// rpm scaling, and two partial products for each of the two filters).
// A new frame is taken only after the previous one has reached the output register.
// The output word sits in its own register; the next frame is accepted and
// processed while it waits, and the sequencer holds in its last step if
// the previous word is still stalled there.
// Reset clears the config registers to their defaults, the turn counter,
// the previous count and both filter accumulators, and drops out_valid.
module motor_feedback_decoder import mfd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ENC_W-1:0]            enc_raw,
  input  logic signed [RPM_W-1:0]     speed_rpm,
  input  logic signed [CUR_W-1:0]     current_raw,
  input  logic [TEMP_W-1:0]           temp_raw,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ENC_W-1:0]            enc_zeroed,
  output logic [ANG_W-1:0]            angle_single,
  output logic signed [TURN_W-1:0]    turn_count,
  output logic signed [TOT_W-1:0]     angle_total,
  output logic signed [SPD_W-1:0]     speed_dps,
  output logic signed [CURF_W-1:0]    current_filt,
  output logic [TEMP_W-1:0]           temperature
);

  ctl_t ctl;

  // config registers
  logic [ENC_W-1:0]   enc_offset;
  logic [APC_W-1:0]   angle_per_count;
  logic [R2D_W-1:0]   rpm_to_dps;
  logic [ALPHA_W-1:0] speed_alpha;
  logic [ALPHA_W-1:0] current_alpha;

  // latched frame
  logic [ENC_W-1:0]        raw_q;
  logic signed [RPM_W-1:0] rpm_q;
  logic signed [CUR_W-1:0] cur_q;
  logic [TEMP_W-1:0]       temp_q;

  // working registers
  logic [ENC_W-1:0]        enc;
  logic [ANG_W-1:0]        ang;
  logic signed [SDF_W-1:0] sdiff;
  logic signed [CDF_W-1:0] cdiff;
  logic signed [M_W-1:0]   m360;
  logic [MUL_PW-1:0]       plo;

  // tracking state
  logic [ENC_W-1:0]         prev_enc;
  logic signed [TURN_W-1:0] turns;
  logic signed [SPD_W-1:0]  speed_acc;
  logic signed [CURF_W-1:0] current_acc;

  // multiplier
  logic signed [MUL_XW-1:0] mx;
  logic signed [MUL_YW-1:0] my;
  logic signed [MUL_PW-1:0] p;

  logic signed [MUL_YW-1:0] a_spd, a_cur;

  mfd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  mfd_mul u_mul (
    .clk (clk),
    .x   (mx),
    .y   (my),
    .p   (p)
  );

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_offset      <= '0;
      angle_per_count <= 24'd737280;
      rpm_to_dps      <= 24'd393216;
      speed_alpha     <= ALPHA_ONE;
      current_alpha   <= ALPHA_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENC_OFFSET:      enc_offset      <= cfg_data[ENC_W-1:0];
        REG_ANGLE_PER_COUNT: angle_per_count <= cfg_data[APC_W-1:0];
        REG_RPM_TO_DPS:      rpm_to_dps      <= cfg_data[R2D_W-1:0];
        REG_SPEED_ALPHA:     speed_alpha     <= cfg_data[ALPHA_W-1:0];
        REG_CURRENT_ALPHA:   current_alpha   <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // weights above one act as one
  assign a_spd = (speed_alpha > ALPHA_ONE) ? {1'b0, ALPHA_ONE} : {1'b0, speed_alpha};
  assign a_cur = (current_alpha > ALPHA_ONE) ? {1'b0, ALPHA_ONE} : {1'b0, current_alpha};

  // ---------------- multiplier operands ----------------
  always_comb begin
    mx = '0;
    my = '0;
    unique case (ctl.mop)
      MOP_ANG: begin
        mx = {{(MUL_XW-APC_W){1'b0}}, angle_per_count};
        my = {{(MUL_YW-ENC_W){1'b0}}, enc};
      end
      MOP_RPM: begin
        mx = {{(MUL_XW-R2D_W){1'b0}}, rpm_to_dps};
        my = {{(MUL_YW-RPM_W){rpm_q[RPM_W-1]}}, rpm_q};
      end
      MOP_SLO: begin
        mx = {{(MUL_XW-LO_W){1'b0}}, sdiff[LO_W-1:0]};
        my = a_spd;
      end
      MOP_SHI: begin
        mx = {{(MUL_XW-(SDF_W-LO_W)){sdiff[SDF_W-1]}}, sdiff[SDF_W-1:LO_W]};
        my = a_spd;
      end
      MOP_CLO: begin
        mx = {{(MUL_XW-LO_W){1'b0}}, cdiff[LO_W-1:0]};
        my = a_cur;
      end
      MOP_CHI: begin
        mx = {{(MUL_XW-(CDF_W-LO_W)){cdiff[CDF_W-1]}}, cdiff[CDF_W-1:LO_W]};
        my = a_cur;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  // ---------------- zero offset ----------------
  logic [ENC_W:0] enc_dif, enc_fix;

  always_comb begin
    enc_dif = {1'b0, raw_q} - {1'b0, enc_offset};
    // below zero: wrap by 8191 counts
    enc_fix = enc_dif + (enc_dif[ENC_W] ? {1'b0, ENC_WRAP} : '0);
  end

  // ---------------- angle scaling ----------------
  logic [MUL_PW-1:0] ang_shf;
  logic              ang_ovf;

  always_comb begin
    ang_shf = p >> ANG_SH;
    ang_ovf = |ang_shf[MUL_PW-1:ANG_W];
  end

  // ---------------- turn tracking ----------------
  logic signed [ENC_W:0] turn_d;

  assign turn_d = $signed({1'b0, enc}) - $signed({1'b0, prev_enc});

  // ---------------- filter samples ----------------
  logic signed [SPW-1:0]   spd_ext, spd_scl;
  logic [SPW-SPD_W:0]      spd_top;
  logic signed [SPD_W-1:0] spd_smp;
  logic signed [CWW-1:0]   cur_scl;
  logic [CWW-CURF_W:0]     cur_top;
  logic signed [CURF_W-1:0] cur_smp;
  logic signed [M_W-1:0]   tx;

  always_comb begin
    spd_ext = SPW'(signed'(p[SPD_W-1:0]));
    spd_scl = (spd_ext <<< SHL) >>> SHR;
    spd_top = spd_scl[SPW-1:SPD_W-1];
    if ((&spd_top) || !(|spd_top)) begin
      spd_smp = spd_scl[SPD_W-1:0];
    end else begin
      spd_smp = spd_scl[SPW-1] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
    end

    cur_scl = CWW'(cur_q) <<< FRAC_BITS;
    cur_top = cur_scl[CWW-1:CURF_W-1];
    if ((&cur_top) || !(|cur_top)) begin
      cur_smp = cur_scl[CURF_W-1:0];
    end else begin
      cur_smp = cur_scl[CWW-1] ? {1'b1, {(CURF_W-1){1'b0}}} : {1'b0, {(CURF_W-1){1'b1}}};
    end

    // turns * 360 = turns * (256 + 64 + 32 + 8)
    tx = M_W'(turns);
  end

  // ---------------- total angle ----------------
  logic [M_W-M_KEEP:0]   m_top;
  logic signed [TSW-1:0] tsum;
  logic signed [TOT_W-1:0] total;

  always_comb begin
    m_top = m360[M_W-1:M_KEEP-1];
    tsum  = (TSW'(signed'(m360[M_KEEP-1:0])) <<< FRAC_BITS) + TSW'(ang);
    if (!((&m_top) || !(|m_top))) begin
      total = m360[M_W-1] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else if (tsum[TSW-1] != tsum[TSW-2]) begin
      total = tsum[TSW-1] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else begin
      total = tsum[TOT_W-1:0];
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      raw_q  <= enc_raw;
      rpm_q  <= speed_rpm;
      cur_q  <= current_raw;
      temp_q <= temp_raw;
    end
    if (ctl.ld_enc) begin
      enc <= enc_fix[ENC_W-1:0];
    end
    if (ctl.ld_ang) begin
      ang <= ang_ovf ? {ANG_W{1'b1}} : ang_shf[ANG_W-1:0];
    end
    if (ctl.ld_diff) begin
      sdiff <= SDF_W'(spd_smp) - SDF_W'(speed_acc);
      cdiff <= CDF_W'(cur_smp) - CDF_W'(current_acc);
      m360  <= (tx <<< 8) + (tx <<< 6) + (tx <<< 5) + (tx <<< 3);
    end
    if (ctl.ld_plo) begin
      plo <= p;
    end
  end

  // low partial product is never negative, so the floor splits cleanly
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_enc    <= '0;
      turns       <= '0;
      speed_acc   <= '0;
      current_acc <= '0;
    end else begin
      if (ctl.ld_turn) begin
        prev_enc <= enc;
        if (turn_d > $signed(HALF_TURN)) begin
          turns <= turns - 32'sd1;
        end else if (turn_d < -$signed(HALF_TURN)) begin
          turns <= turns + 32'sd1;
        end
      end
      if (ctl.upd_spd) begin
        speed_acc <= speed_acc + SPD_W'(p <<< 8) + SPD_W'(plo[MUL_PW-1:16]);
      end
      if (ctl.upd_cur) begin
        current_acc <= current_acc + CURF_W'(p <<< 8) + CURF_W'(plo[MUL_PW-1:16]);
      end
    end
  end

  // ---------------- output word ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      enc_zeroed   <= enc;
      angle_single <= ang;
      turn_count   <= turns;
      angle_total  <= total;
      speed_dps    <= speed_acc;
      current_filt <= current_acc;
      temperature  <= temp_q;
    end
  end

  // ---------------- assertions ----------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.ld_out))
    else $error("out_valid rose without a load from the sequencer");

  a_turn_step: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_turn |=> (turns == $past(turns) || turns == $past(turns) + 32'sd1 ||
                     turns == $past(turns) - 32'sd1))
    else $error("turn counter moved by more than one per frame");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_in |=> in_stall)
    else $error("input not stalled while a frame is in flight");

  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output word valid right after reset");

endmodule

/* rtl/mfd_mul.sv */
module mfd_mul import mfd_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_XW-1:0] x,
  input  logic signed [MUL_YW-1:0] y,
  output logic signed [MUL_PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= x * y;
  end

endmodule

/* rtl/mfd_seq.sv */
module mfd_seq import mfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_valid,
  input  logic out_stall,
  output logic in_stall,
  output ctl_t ctl
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_ZERO;
      ST_ZERO: state_next = ST_ANG;
      ST_ANG:  state_next = ST_RPM;
      ST_RPM:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SLO;
      ST_SLO:  state_next = ST_SHI;
      ST_SHI:  state_next = ST_CLO;
      ST_CLO:  state_next = ST_CHI;
      ST_CHI:  state_next = ST_CACC;
      ST_CACC: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.mop  = MOP_ANG;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.ld_in  = in_valid;
      end
      ST_ZERO: ctl.ld_enc = 1'b1;
      ST_ANG:  ctl.mop = MOP_ANG;
      ST_RPM: begin
        ctl.mop     = MOP_RPM;
        ctl.ld_ang  = 1'b1;
        ctl.ld_turn = 1'b1;
      end
      ST_DIFF: ctl.ld_diff = 1'b1;
      ST_SLO:  ctl.mop = MOP_SLO;
      ST_SHI: begin
        ctl.mop    = MOP_SHI;
        ctl.ld_plo = 1'b1;
      end
      ST_CLO: begin
        ctl.mop     = MOP_CLO;
        ctl.upd_spd = 1'b1;
      end
      ST_CHI: begin
        ctl.mop    = MOP_CHI;
        ctl.ld_plo = 1'b1;
      end
      ST_CACC: ctl.upd_cur = 1'b1;
      ST_DONE: ctl.ld_out = out_free;
      default: ctl = '0;
    endcase
  end

endmodule

/* bench/motor_feedback_decoder_checker.sv */
module motor_feedback_decoder_checker import mfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [ENC_W-1:0]         enc_raw,
  input  logic signed [RPM_W-1:0]  speed_rpm,
  input  logic signed [CUR_W-1:0]  current_raw,
  input  logic [TEMP_W-1:0]        temp_raw,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [ENC_W-1:0]         enc_zeroed,
  input  logic [ANG_W-1:0]         angle_single,
  input  logic signed [TURN_W-1:0] turn_count,
  input  logic signed [TOT_W-1:0]  angle_total,
  input  logic signed [SPD_W-1:0]  speed_dps,
  input  logic signed [CURF_W-1:0] current_filt,
  input  logic [TEMP_W-1:0]        temperature,
  output int                       errors,
  output int                       pending,
  output int                       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HALF_REV    = int'(HALF_TURN);
  localparam longint DEG_PER_REV = 360;
  localparam int     WEIGHT_FRAC = 16;
  localparam longint ANG_LIMIT   = (longint'(1) <<< ANG_W) - 1;

  typedef struct {
    logic [ENC_W-1:0]         enc;
    logic [ANG_W-1:0]         angle;
    logic signed [TURN_W-1:0] turns;
    logic signed [TOT_W-1:0]  total;
    logic signed [SPD_W-1:0]  speed;
    logic signed [CURF_W-1:0] amps;
    logic [TEMP_W-1:0]        heat;
  } decoded_t;

  decoded_t due_words[$];

  // register copies
  logic [ENC_W-1:0]   zero_off;
  logic [APC_W-1:0]   deg_per_count;
  logic [R2D_W-1:0]   rpm_scale;
  logic [ALPHA_W-1:0] spd_weight;
  logic [ALPHA_W-1:0] cur_weight;

  // tracking and filter state
  logic [ENC_W-1:0]         last_count;
  logic signed [TURN_W-1:0] turn_acc;
  longint                   spd_filt;
  longint                   cur_filt;

  int fail_count = 0;
  int n_checked  = 0;
  int queued     = 0;

  assign errors  = fail_count;
  assign pending = queued;
  assign checked = n_checked;

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint smooth(longint acc, longint smp, logic [ALPHA_W-1:0] wt);
    longint a;
    a = (wt > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(wt);
    return acc + ((a * (smp - acc)) >>> WEIGHT_FRAC);
  endfunction

  function automatic decoded_t decode_frame(input logic [ENC_W-1:0] raw,
                                            input logic signed [RPM_W-1:0] rpm,
                                            input logic signed [CUR_W-1:0] amps,
                                            input logic [TEMP_W-1:0] heat);
    decoded_t r;
    logic [ENC_W:0] zc;
    longint ang;
    longint spd;
    longint amp;
    longint m;
    longint tot;
    longint bound;
    int d;
    if (raw >= zero_off)
      zc = {1'b0, raw} - {1'b0, zero_off};
    else
      zc = {1'b0, raw} + {1'b0, ENC_WRAP} - {1'b0, zero_off};
    r.enc = zc[ENC_W-1:0];

    ang = (longint'(r.enc) * longint'(deg_per_count)) >> ANG_SH;
    if (ang > ANG_LIMIT) ang = ANG_LIMIT;

    spd = longint'(rpm) * longint'(rpm_scale);
    spd = (spd <<< SHL) >>> SHR;
    spd_filt = smooth(spd_filt, clamp(spd, SPD_W), spd_weight);

    amp = clamp(longint'(amps) <<< FRAC_BITS, CURF_W);
    cur_filt = smooth(cur_filt, amp, cur_weight);

    // more than half a revolution between frames is a wrap
    d = int'(r.enc) - int'(last_count);
    if (d > HALF_REV)
      turn_acc = turn_acc - 1;
    else if (d < -HALF_REV)
      turn_acc = turn_acc + 1;
    last_count = r.enc;

    m = longint'(turn_acc) * DEG_PER_REV;
    bound = (longint'(1) <<< (TOT_W - 1)) >>> FRAC_BITS;
    if (m >= bound)
      tot = clamp(longint'(1) <<< 62, TOT_W);
    else if (m < -bound)
      tot = clamp(-(longint'(1) <<< 62), TOT_W);
    else
      tot = clamp((m <<< FRAC_BITS) + ang, TOT_W);

    r.angle = ang[ANG_W-1:0];
    r.turns = turn_acc;
    r.total = tot[TOT_W-1:0];
    r.speed = spd_filt[SPD_W-1:0];
    r.amps  = cur_filt[CURF_W-1:0];
    r.heat  = heat;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst) begin
      zero_off      = '0;
      deg_per_count = 24'd737280;
      rpm_scale     = 24'd393216;
      spd_weight    = ALPHA_ONE;
      cur_weight    = ALPHA_ONE;
      last_count    = '0;
      turn_acc      = '0;
      spd_filt      = 0;
      cur_filt      = 0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENC_OFFSET:      zero_off      = cfg_data[ENC_W-1:0];
          REG_ANGLE_PER_COUNT: deg_per_count = cfg_data[APC_W-1:0];
          REG_RPM_TO_DPS:      rpm_scale     = cfg_data[R2D_W-1:0];
          REG_SPEED_ALPHA:     spd_weight    = cfg_data[ALPHA_W-1:0];
          REG_CURRENT_ALPHA:   cur_weight    = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("decoded word with no frame outstanding");
          fail_count++;
        end else begin
          want = due_words.pop_front();
          check_field("enc_zeroed", want.enc, enc_zeroed);
          check_field("angle_single", want.angle, angle_single);
          check_field("turn_count", want.turns, turn_count);
          check_field("angle_total", want.total, angle_total);
          check_field("speed_dps", want.speed, speed_dps);
          check_field("current_filt", want.amps, current_filt);
          check_field("temperature", want.heat, temperature);
          n_checked++;
        end
      end
      if (in_valid && !in_stall)
        due_words.push_back(decode_frame(enc_raw, speed_rpm, current_raw, temp_raw));
    end
    queued <= due_words.size();
  end

endmodule

/* bench/motor_feedback_decoder_tb.sv */
module motor_feedback_decoder_tb;
  import mfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int REV_COUNTS = 8192;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DAT_W-1:0]     cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ENC_W-1:0]         enc_raw = '0;
  logic signed [RPM_W-1:0]  speed_rpm = '0;
  logic signed [CUR_W-1:0]  current_raw = '0;
  logic [TEMP_W-1:0]        temp_raw = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ENC_W-1:0]         enc_zeroed;
  logic [ANG_W-1:0]         angle_single;
  logic signed [TURN_W-1:0] turn_count;
  logic signed [TOT_W-1:0]  angle_total;
  logic signed [SPD_W-1:0]  speed_dps;
  logic signed [CURF_W-1:0] current_filt;
  logic [TEMP_W-1:0]        temperature;

  int errors;
  int pending;
  int checked;

  logic calm = 1'b0;       // no idling on either side
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   n_settings = 0;
  int   pos = 0;
  int   dir = 1;

  motor_feedback_decoder u_dut (.*);

  motor_feedback_decoder_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  task automatic send_frame(input logic [ENC_W-1:0] e, input logic signed [RPM_W-1:0] r,
                            input logic signed [CUR_W-1:0] c, input logic [TEMP_W-1:0] t);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    enc_raw     <= e;
    speed_rpm   <= r;
    current_raw <= c;
    temp_raw    <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [CFG_DAT_W-1:0] off, input logic [CFG_DAT_W-1:0] apc,
                               input logic [CFG_DAT_W-1:0] r2d, input logic [CFG_DAT_W-1:0] sa,
                               input logic [CFG_DAT_W-1:0] ca);
    write_reg(REG_ENC_OFFSET, off);
    write_reg(REG_ANGLE_PER_COUNT, apc);
    write_reg(REG_RPM_TO_DPS, r2d);
    write_reg(REG_SPEED_ALPHA, sa);
    write_reg(REG_CURRENT_ALPHA, ca);
    // no such register, must not disturb anything
    write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // wait until every word in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_value(int unsigned hi, int unsigned dflt);
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_DAT_W'(hi);
      2: return CFG_DAT_W'(dflt);
      3: return CFG_DAT_W'($urandom);  // upper bits beyond the register are dropped
      default: return CFG_DAT_W'($urandom_range(hi));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_DAT_W'(ALPHA_ONE);
      2: return CFG_DAT_W'($urandom_range(17'h1FFFF, 17'h10001));  // clamps to one
      default: return CFG_DAT_W'($urandom_range(ALPHA_ONE));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // rotor mostly turning one way, with the odd back step, near-half jumps and glitches
  task automatic rotate_and_send();
    case ($urandom_range(9))
      0: pos = $urandom_range(REV_COUNTS - 1);
      1: pos = pos + dir * int'($urandom_range(4300, 3900));
      2: pos = pos - dir * int'($urandom_range(300));
      default: pos = pos + dir * int'($urandom_range(700));
    endcase
    pos = ((pos % REV_COUNTS) + REV_COUNTS) % REV_COUNTS;
    send_frame(ENC_W'(pos), pick_level(), pick_level(), TEMP_W'($urandom));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first frame high counts a turn down, then both wraps
    send_frame(13'd8191, 16'sh7FFF, 16'sh7FFF, 8'd255);
    send_frame(13'd0, 16'sh8000, 16'sh8000, 8'd0);
    send_frame(13'd4096, 16'sd1, -16'sd1, 8'h55);   // exactly half: no turn
    send_frame(13'd0, -16'sd1, 16'sd1, 8'hAA);
    send_frame(13'd4097, 16'sd0, 16'sd0, 8'd1);     // just over half: down
    send_frame(13'd0, 16'sd100, -16'sd100, 8'd2);   // and back up
    send_frame(13'h1555, 16'sh5555, 16'shAAAA, 8'hAA);
    send_frame(13'h0AAA, 16'shAAAA, 16'sh5555, 8'h55);
    drain();

    // offset at top, angle saturates, overweight speed filter, frozen current filter
    load_settings(24'd8191, 24'hFFFFFF, 24'hFFFFFF, 24'h1FFFF, 24'd0);
    send_frame(13'd0, 16'sh7FFF, 16'sh7FFF, 8'd3);
    send_frame(13'd8191, 16'sh8000, 16'sh8000, 8'd4);
    send_frame(13'd100, 16'sd1, -16'sd1, 8'd5);
    send_frame(13'd8190, -16'sd1, 16'sd1, 8'd6);
    drain();

    // count below offset wraps, zero scales, minimal and near-full weights
    load_settings(24'd1, 24'd0, 24'd0, 24'd1, 24'd65535);
    send_frame(13'd0, 16'sh7FFF, 16'sh8000, 8'd7);
    send_frame(13'd1, 16'sh8000, 16'sh7FFF, 8'd8);
    send_frame(13'd8191, 16'sd1234, -16'sd4321, 8'd9);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        load_settings(24'd0, 24'd737280, 24'd393216, 24'd65536, 24'd65536);
      else
        load_settings(pick_value(8191, 0), pick_value(24'hFFFFFF, 737280),
                      pick_value(24'hFFFFFF, 393216), pick_weight(), pick_weight());
      dir = ph[0] ? -1 : 1;
      calm <= (ph == 4);
      if (ph == 2)
        hold_go <= 1'b1;
      repeat (172) rotate_and_send();
      drain();
    end
    calm <= 1'b0;

    repeat (40) @(posedge clk);
    $display("%0d feedback frames decoded and compared over %0d register settings,",
             checked, n_settings);
    $display("with both rotation directions, a long output hold-off and idle drains");
    if (errors == 0 && pending == 0)
      $display("motor_feedback_decoder test passed");
    else
      $display("motor_feedback_decoder test failed");
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("motor_feedback_decoder test failed");
    $finish;
  end

endmodule
